[rtl/core/tkmac_pkg.sv]
// shared types, constants and aes helpers for the two-key cbc-mac unit
`timescale 1ns / 1ps
package tkmac_pkg;

  localparam int BlkW = 128;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegKeyFirstHi = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyFirstLo = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyFinalHi = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyFinalLo = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInitHi = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInitLo = 3'd5;

  // classified work item handed from front to back
  typedef struct packed {
    logic [BlkW-1:0] data;
    logic            last;
  } work_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit word, byte 0 most significant
  function automatic logic [7:0] byte_at(input logic [BlkW-1:0] w, input int i);
    byte_at = w[BlkW-1-8*i -: 8];
  endfunction

  // one round: subbytes, shiftrows, optional mixcolumns, add round key
  function automatic logic [BlkW-1:0] aes_round(input logic [BlkW-1:0] st,
                                                input logic [BlkW-1:0] rk,
                                                input logic            mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [BlkW-1:0] res;
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++)
        t[c*4+j] = Sbox[byte_at(st, ((c + j) % 4) * 4 + j)];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++)
      res[BlkW-1-8*i -: 8] = t[i];
    aes_round = res ^ rk;
  endfunction

  // next round key from the current one
  function automatic logic [BlkW-1:0] key_step(input logic [BlkW-1:0] k,
                                               input logic [7:0]      rcon);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    tw = {Sbox[w3[23:16]] ^ rcon, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/core/tkmac_if.sv]
// valid/ready channel interfaces for input blocks and mac results
`timescale 1ns / 1ps
interface tkmac_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic [4:0]  valid_bytes;
  logic        last_block;
  modport source (output valid, block_hi, block_lo, valid_bytes, last_block, input ready);
  modport sink (input valid, block_hi, block_lo, valid_bytes, last_block, output ready);
endinterface

interface tkmac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] mac_hi;
  logic [63:0] mac_lo;
  modport source (output valid, mac_hi, mac_lo, input ready);
  modport sink (input valid, mac_hi, mac_lo, output ready);
endinterface

[rtl/core/tkmac_front.sv]
// front: masks the tail of a last block and queues classified items
`timescale 1ns / 1ps
module tkmac_front (
  input  logic                  clk,
  input  logic                  rst_n,
  tkmac_in_if.sink              in_ch,
  output tkmac_pkg::work_t      wk,
  output logic                  wk_valid,
  input  logic                  wk_take
);
  tkmac_pkg::work_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  tkmac_pkg::work_t cls;
  logic [tkmac_pkg::BlkW-1:0] mask;
  logic push, pop;

  always_comb begin
    for (int i = 0; i < 16; i++)
      mask[tkmac_pkg::BlkW-1-8*i -: 8] =
        (!in_ch.last_block || in_ch.valid_bytes > 5'(i)) ? 8'hff : 8'h00;
    cls.data = {in_ch.block_hi, in_ch.block_lo} & mask;
    cls.last = in_ch.last_block;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign wk_valid = (cnt_r != 2'd0);
  assign pop = wk_valid && wk_take;
  assign wk = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
    end
    if (push) q_r[wr_r] <= cls;
  end
endmodule

[rtl/core/tkmac_back.sv]
// back: iterative aes-128 round core with the cbc chain and mac register
`timescale 1ns / 1ps
module tkmac_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkmac_pkg::work_t            wk,
  input  logic                        wk_valid,
  output logic                        wk_take,
  input  logic [tkmac_pkg::BlkW-1:0]  key_first,
  input  logic [tkmac_pkg::BlkW-1:0]  key_final,
  input  logic [tkmac_pkg::BlkW-1:0]  init_chain,
  tkmac_out_if.source                 out_ch
);
  typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;
  state_t state_r;
  logic [tkmac_pkg::BlkW-1:0] st_r, rk_r, chain_r, mac_r;
  logic [3:0] round_r;
  logic [7:0] rcon_r;
  logic last_r, in_msg_r, ov_r;
  logic [tkmac_pkg::BlkW-1:0] rk_nxt, st_nxt, chain_in, key_in;
  logic done, mac_load;

  assign out_ch.valid  = ov_r;
  assign out_ch.mac_hi = mac_r[127:64];
  assign out_ch.mac_lo = mac_r[63:0];

  assign done = (state_r == ST_RUN) && (round_r == 4'd10);
  // a finishing last block needs the output slot free
  assign mac_load = done && last_r && (!ov_r || out_ch.ready);
  assign wk_take = (state_r == ST_IDLE) && wk_valid;
  assign chain_in = in_msg_r ? chain_r : init_chain;
  assign key_in = wk.last ? key_final : key_first;
  assign rk_nxt = tkmac_pkg::key_step(rk_r, rcon_r);
  assign st_nxt = tkmac_pkg::aes_round(st_r, rk_nxt, round_r != 4'd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      in_msg_r <= 1'b0;
      ov_r     <= 1'b0;
      round_r  <= '0;
    end else begin
      if (mac_load) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (wk_valid) begin
            st_r    <= chain_in ^ wk.data ^ key_in;
            rk_r    <= key_in;
            rcon_r  <= 8'h01;
            last_r  <= wk.last;
            round_r <= 4'd1;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (round_r != 4'd10) begin
            st_r    <= st_nxt;
            rk_r    <= rk_nxt;
            rcon_r  <= tkmac_pkg::xtime(rcon_r);
            round_r <= round_r + 4'd1;
          end else if (!last_r) begin
            chain_r  <= st_nxt;
            in_msg_r <= 1'b1;
            state_r  <= ST_IDLE;
          end else if (mac_load) begin
            mac_r    <= st_nxt;
            in_msg_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/two_key_cbc_mac_aes128_unit.sv]
// top level of the two-key cbc-mac aes-128 unit
// a last block's mac is registered once the core has finished its rounds and the output slot is free
// the ten-round iterative aes core takes a new item only when idle, after it has finished the item before
// the two-entry front queue takes items while the core runs or a mac waits
// synchronous active-low reset clears queue, core state, chain flag, registers
`timescale 1ns / 1ps
module two_key_cbc_mac_aes128_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  tkmac_in_if.sink                        in_ch,
  tkmac_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [tkmac_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tkmac_pkg::CfgDataW-1:0]  cfg_data
);
  // configuration registers
  logic [63:0] kf_hi_r, kf_lo_r, kl_hi_r, kl_lo_r, ic_hi_r, ic_lo_r;
  tkmac_pkg::work_t wk;
  logic wk_valid, wk_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kf_hi_r <= '0; kf_lo_r <= '0;
      kl_hi_r <= '0; kl_lo_r <= '0;
      ic_hi_r <= '0; ic_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tkmac_pkg::RegKeyFirstHi: kf_hi_r <= cfg_data;
        tkmac_pkg::RegKeyFirstLo: kf_lo_r <= cfg_data;
        tkmac_pkg::RegKeyFinalHi: kl_hi_r <= cfg_data;
        tkmac_pkg::RegKeyFinalLo: kl_lo_r <= cfg_data;
        tkmac_pkg::RegInitHi:     ic_hi_r <= cfg_data;
        tkmac_pkg::RegInitLo:     ic_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: tail masking and queue
  tkmac_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .wk(wk), .wk_valid(wk_valid), .wk_take(wk_take)
  );

  // back: chain and aes rounds
  tkmac_back u_back (
    .clk(clk), .rst_n(rst_n),
    .wk(wk), .wk_valid(wk_valid), .wk_take(wk_take),
    .key_first({kf_hi_r, kf_lo_r}),
    .key_final({kl_hi_r, kl_lo_r}),
    .init_chain({ic_hi_r, ic_lo_r}),
    .out_ch(out_ch)
  );
endmodule
